>>> rtl/bmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmm_pkg;

  // Field and register widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned DELTA_W = 7;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ANGLE_W = 23;
  localparam int unsigned TRIG_W  = 3;

  // Direction lanes: up, down, left, right
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned LANE_UP    = 0;
  localparam int unsigned LANE_DOWN  = 1;
  localparam int unsigned LANE_LEFT  = 2;
  localparam int unsigned LANE_RIGHT = 3;

  // Output queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_REPORT_INTERVAL = 3'd0;
  localparam logic [IDX_W-1:0] REG_TOGGLE_LOCKOUT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SLOW_AFTER      = 3'd2;
  localparam logic [IDX_W-1:0] REG_MEDIUM_AFTER    = 3'd3;
  localparam logic [IDX_W-1:0] REG_FAST_AFTER      = 3'd4;
  localparam logic [IDX_W-1:0] REG_SLOW_STEP       = 3'd5;
  localparam logic [IDX_W-1:0] REG_MEDIUM_STEP     = 3'd6;
  localparam logic [IDX_W-1:0] REG_FAST_STEP       = 3'd7;

  // Reset values of the registers
  localparam logic [CFG_W-1:0]  RST_REPORT_INTERVAL = 16'd10;
  localparam logic [CFG_W-1:0]  RST_TOGGLE_LOCKOUT  = 16'd300;
  localparam logic [CFG_W-1:0]  RST_SLOW_AFTER      = 16'd100;
  localparam logic [CFG_W-1:0]  RST_MEDIUM_AFTER    = 16'd500;
  localparam logic [CFG_W-1:0]  RST_FAST_AFTER      = 16'd1000;
  localparam logic [STEP_W-1:0] RST_SLOW_STEP       = 6'd1;
  localparam logic [STEP_W-1:0] RST_MEDIUM_STEP     = 6'd3;
  localparam logic [STEP_W-1:0] RST_FAST_STEP       = 6'd5;

  // Circle angle, unsigned Q3.20: 0.1 rad step, wrap at 6.28318 rad
  localparam logic [ANGLE_W-1:0] ANGLE_STEP = 23'd104858;
  localparam logic [ANGLE_W-1:0] ANGLE_WRAP = 23'd6588392;

  // Hold-time thresholds and step sizes shared by all lanes
  typedef struct packed {
    logic [CFG_W-1:0]  slow_after;
    logic [CFG_W-1:0]  medium_after;
    logic [CFG_W-1:0]  fast_after;
    logic [STEP_W-1:0] slow_step;
    logic [STEP_W-1:0] medium_step;
    logic [STEP_W-1:0] fast_step;
  } lane_cfg_t;

  // One motion report
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic                      mode_led;
  } report_t;

endpackage

`default_nettype wire

>>> rtl/bmm_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One direction button: press tracking, hold time, step selection.
module bmm_lane (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              track,
  input  wire logic                              pressed,
  input  wire logic [bmm_pkg::TIME_W-1:0]        now_ms,
  input  wire bmm_pkg::lane_cfg_t                cfg,
  output logic      [bmm_pkg::STEP_W-1:0]        step
);

  logic                         held;
  logic [bmm_pkg::TIME_W-1:0]   start;
  logic                         active;
  logic [bmm_pkg::TIME_W-1:0]   hold_time;
  logic [bmm_pkg::STEP_W-1:0]   step_next;

  // Press state, updated only on reporting polls in button mode
  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      start <= '0;
    end else if (track) begin
      if (pressed) begin
        if (!held) begin
          held  <= 1'b1;
          start <= now_ms;
        end
      end else begin
        held  <= 1'b0;
        start <= '0;
      end
    end
  end

  // Stage 1: hold time as of this poll (zero on a new press)
  always_ff @(posedge clk) begin
    active    <= pressed;
    hold_time <= (pressed && held) ? (now_ms - start) : '0;
  end

  // Stage 2: threshold compare picks the step
  always_comb begin
    step_next = '0;
    if (active) begin
      if (hold_time > {16'd0, cfg.fast_after}) begin
        step_next = cfg.fast_step;
      end else if (hold_time > {16'd0, cfg.medium_after}) begin
        step_next = cfg.medium_step;
      end else if (hold_time > {16'd0, cfg.slow_after}) begin
        step_next = cfg.slow_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    step <= step_next;
  end

endmodule

`default_nettype wire

>>> rtl/bmm_circle.sv
`timescale 1ns / 1ps
`default_nettype none

// Circle angle accumulator and 3*cos / 3*sin breakpoint lookup.
module bmm_circle (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   advance,
  output logic signed [bmm_pkg::TRIG_W-1:0]           cos_val,
  output logic signed [bmm_pkg::TRIG_W-1:0]           sin_val
);

  logic [bmm_pkg::ANGLE_W-1:0] angle;
  logic [bmm_pkg::ANGLE_W-1:0] angle_inc;
  logic [bmm_pkg::ANGLE_W-1:0] angle_next;
  logic [bmm_pkg::ANGLE_W-1:0] angle_q;

  function automatic logic signed [bmm_pkg::TRIG_W-1:0] cos3(
    input logic [bmm_pkg::ANGLE_W-1:0] a
  );
    logic signed [bmm_pkg::TRIG_W-1:0] r;
    if (a == '0) r = 3'sd3;
    else if (a <= 23'd881924 || a >= 23'd5706473) r = 3'sd2;
    else if (a <= 23'd1290754 || a >= 23'd5297643) r = 3'sd1;
    else if (a >= 23'd2412275 && a <= 23'd4176123) r = -3'sd2;
    else if (a >= 23'd2003445 && a <= 23'd4584953) r = -3'sd1;
    else r = 3'sd0;
    return r;
  endfunction

  function automatic logic signed [bmm_pkg::TRIG_W-1:0] sin3(
    input logic [bmm_pkg::ANGLE_W-1:0] a
  );
    logic signed [bmm_pkg::TRIG_W-1:0] r;
    if (a >= 23'd765175 && a <= 23'd2529023) r = 3'sd2;
    else if (a >= 23'd356345 && a <= 23'd2937853) r = 3'sd1;
    else if (a >= 23'd4059374 && a <= 23'd5823222) r = -3'sd2;
    else if (a >= 23'd3650544 && a <= 23'd6232052) r = -3'sd1;
    else r = 3'sd0;
    return r;
  endfunction

  // Step by 0.1 rad and wrap once past 2*pi
  always_comb begin
    angle_inc  = angle + bmm_pkg::ANGLE_STEP;
    angle_next = (angle_inc > bmm_pkg::ANGLE_WRAP) ? (angle_inc - bmm_pkg::ANGLE_WRAP)
                                                    : angle_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
    end else if (advance) begin
      angle <= angle_next;
    end
  end

  // Stage 1: angle for this poll; stage 2: breakpoint lookup
  always_ff @(posedge clk) begin
    angle_q <= angle_next;
    cos_val <= cos3(angle_q);
    sin_val <= sin3(angle_q);
  end

endmodule

`default_nettype wire

>>> rtl/bmm_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Small output queue of finished reports.
module bmm_out_fifo (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire bmm_pkg::report_t                  push_data,
  input  wire logic                              pop,
  output bmm_pkg::report_t                       head,
  output logic      [bmm_pkg::FIFO_CW-1:0]       count
);

  bmm_pkg::report_t               entries [bmm_pkg::FIFO_DEPTH];
  logic [bmm_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [bmm_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [bmm_pkg::FIFO_CW-1:0]    count_next;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head = entries[rd_ptr];

  // Pointers and fill level
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/button_mouse_motion_generator_top.sv
// A reporting poll's result is ready to transfer once it has been written into the output queue.
// Throughput: one poll per cycle; report timing, mode toggle and press state settle
// in the accept cycle, four direction lanes and the circle unit then run 2 stages.
// Input stalls only when 4 results are queued or in flight (4-entry output queue).
// Reset (rst, synchronous, active high) loads register defaults, clears press
// tracking, circle mode, angle, report and toggle stamps, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module button_mouse_motion_generator_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration
  input  wire logic                                  cfg_write,
  input  wire logic        [bmm_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic        [bmm_pkg::CFG_W-1:0]      cfg_data,
  // Poll input
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [bmm_pkg::TIME_W-1:0]     now_ms,
  input  wire logic                                  up_level,
  input  wire logic                                  down_level,
  input  wire logic                                  left_level,
  input  wire logic                                  right_level,
  input  wire logic                                  mode_level,
  // Report output
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [bmm_pkg::DELTA_W-1:0]    delta_x,
  output logic signed      [bmm_pkg::DELTA_W-1:0]    delta_y,
  output logic                                       mode_led
);

  // Configuration registers
  logic [bmm_pkg::CFG_W-1:0] report_interval;
  logic [bmm_pkg::CFG_W-1:0] toggle_lockout;
  bmm_pkg::lane_cfg_t        lane_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_interval       <= bmm_pkg::RST_REPORT_INTERVAL;
      toggle_lockout        <= bmm_pkg::RST_TOGGLE_LOCKOUT;
      lane_cfg.slow_after   <= bmm_pkg::RST_SLOW_AFTER;
      lane_cfg.medium_after <= bmm_pkg::RST_MEDIUM_AFTER;
      lane_cfg.fast_after   <= bmm_pkg::RST_FAST_AFTER;
      lane_cfg.slow_step    <= bmm_pkg::RST_SLOW_STEP;
      lane_cfg.medium_step  <= bmm_pkg::RST_MEDIUM_STEP;
      lane_cfg.fast_step    <= bmm_pkg::RST_FAST_STEP;
    end else if (cfg_write) begin
      case (cfg_index)
        bmm_pkg::REG_REPORT_INTERVAL: report_interval       <= cfg_data;
        bmm_pkg::REG_TOGGLE_LOCKOUT:  toggle_lockout        <= cfg_data;
        bmm_pkg::REG_SLOW_AFTER:      lane_cfg.slow_after   <= cfg_data;
        bmm_pkg::REG_MEDIUM_AFTER:    lane_cfg.medium_after <= cfg_data;
        bmm_pkg::REG_FAST_AFTER:      lane_cfg.fast_after   <= cfg_data;
        bmm_pkg::REG_SLOW_STEP:       lane_cfg.slow_step    <= cfg_data[bmm_pkg::STEP_W-1:0];
        bmm_pkg::REG_MEDIUM_STEP:     lane_cfg.medium_step  <= cfg_data[bmm_pkg::STEP_W-1:0];
        bmm_pkg::REG_FAST_STEP:       lane_cfg.fast_step    <= cfg_data[bmm_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Poll transfer and report timing
  logic                         in_xfer;
  logic                         report_go;
  logic                         toggle;
  logic                         circle;
  logic                         circle_next;
  logic                         prev_mode;
  logic [bmm_pkg::TIME_W-1:0]   report_start;
  logic [bmm_pkg::TIME_W-1:0]   last_toggle;
  logic [bmm_pkg::TIME_W-1:0]   since_report;
  logic [bmm_pkg::TIME_W-1:0]   since_toggle;

  assign in_xfer      = in_valid && !in_stall;
  assign since_report = now_ms - report_start;
  assign since_toggle = now_ms - last_toggle;
  assign report_go    = in_xfer && (since_report >= {16'd0, report_interval});
  assign toggle       = report_go && !mode_level && prev_mode &&
                        (since_toggle > {16'd0, toggle_lockout});
  assign circle_next  = circle ^ toggle;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_start <= '0;
      last_toggle  <= '0;
      prev_mode    <= 1'b1;
      circle       <= 1'b0;
    end else if (report_go) begin
      report_start <= report_start + {16'd0, report_interval};
      prev_mode    <= mode_level;
      circle       <= circle_next;
      if (toggle) last_toggle <= now_ms;
    end
  end

  // Direction lanes
  logic                         lane_track;
  logic [bmm_pkg::NUM_LANES-1:0] lane_pressed;
  logic [bmm_pkg::STEP_W-1:0]   lane_step [bmm_pkg::NUM_LANES];

  assign lane_track = report_go && !circle_next;
  assign lane_pressed[bmm_pkg::LANE_UP]    = !up_level;
  assign lane_pressed[bmm_pkg::LANE_DOWN]  = !down_level;
  assign lane_pressed[bmm_pkg::LANE_LEFT]  = !left_level;
  assign lane_pressed[bmm_pkg::LANE_RIGHT] = !right_level;

  for (genvar g = 0; g < bmm_pkg::NUM_LANES; g++) begin : g_lane
    bmm_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .track   (lane_track),
      .pressed (lane_pressed[g]),
      .now_ms  (now_ms),
      .cfg     (lane_cfg),
      .step    (lane_step[g])
    );
  end

  // Circle unit
  logic signed [bmm_pkg::TRIG_W-1:0] cos_val;
  logic signed [bmm_pkg::TRIG_W-1:0] sin_val;

  bmm_circle u_circle (
    .clk     (clk),
    .rst     (rst),
    .advance (report_go && circle_next),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  // Stage tracking
  logic valid1;
  logic valid2;
  logic circ1;
  logic circ2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      valid1 <= report_go;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    circ1 <= circle_next;
    circ2 <= circ1;
  end

  // Merge: lane differences or circle values
  bmm_pkg::report_t merged;
  logic signed [bmm_pkg::DELTA_W-1:0] lane_dx;
  logic signed [bmm_pkg::DELTA_W-1:0] lane_dy;

  always_comb begin
    lane_dx = $signed({1'b0, lane_step[bmm_pkg::LANE_RIGHT]}) -
              $signed({1'b0, lane_step[bmm_pkg::LANE_LEFT]});
    lane_dy = $signed({1'b0, lane_step[bmm_pkg::LANE_DOWN]}) -
              $signed({1'b0, lane_step[bmm_pkg::LANE_UP]});
    merged.mode_led = circ2;
    if (circ2) begin
      merged.delta_x = {{(bmm_pkg::DELTA_W-bmm_pkg::TRIG_W){cos_val[bmm_pkg::TRIG_W-1]}},
                        cos_val};
      merged.delta_y = {{(bmm_pkg::DELTA_W-bmm_pkg::TRIG_W){sin_val[bmm_pkg::TRIG_W-1]}},
                        sin_val};
    end else begin
      merged.delta_x = lane_dx;
      merged.delta_y = lane_dy;
    end
  end

  // Output queue
  bmm_pkg::report_t              head;
  logic [bmm_pkg::FIFO_CW-1:0]   fifo_count;
  logic                          out_xfer;
  logic [bmm_pkg::FIFO_CW:0]     occupancy;

  assign out_valid = (fifo_count != '0);
  assign out_xfer  = out_valid && !out_stall;

  bmm_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (valid2),
    .push_data (merged),
    .pop       (out_xfer),
    .head      (head),
    .count     (fifo_count)
  );

  assign delta_x  = head.delta_x;
  assign delta_y  = head.delta_y;
  assign mode_led = head.mode_led;

  // Hold input while the queue could overflow with what is in flight
  assign occupancy = {1'b0, fifo_count} + {{bmm_pkg::FIFO_CW{1'b0}}, valid1} +
                     {{bmm_pkg::FIFO_CW{1'b0}}, valid2};
  assign in_stall  = (occupancy >= (bmm_pkg::FIFO_CW + 1)'(bmm_pkg::FIFO_DEPTH));

  // Checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (bmm_pkg::FIFO_CW + 1)'(bmm_pkg::FIFO_DEPTH))
    else $error("output queue plus in-flight reports exceed queue depth");

  a_circle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_led |-> (delta_x >= -7'sd3) && (delta_x <= 7'sd3) &&
                              (delta_y >= -7'sd3) && (delta_y <= 7'sd3))
    else $error("circle mode report outside -3..3");

  a_toggle_on_report: assert property (@(posedge clk) disable iff (rst)
    (circle != $past(circle)) |-> $past(report_go))
    else $error("circle mode changed on a poll that did not report");

  a_report_advance: assert property (@(posedge clk) disable iff (rst)
    report_go |=> valid1)
    else $error("reporting poll did not enter the pipeline");

endmodule

`default_nettype wire
